// ===== hdl/wspr_message_symbol_encoder_assert.svh =====
// Assertion macros shared by the encoder modules.
// Uses the clk and arst_n names of the including module.
`ifndef WSPR_MESSAGE_SYMBOL_ENCODER_ASSERT_SVH
`define WSPR_MESSAGE_SYMBOL_ENCODER_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define WSPR_ENC_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("encoder check failed");
// The consequent must hold in the cycle after the antecedent.
`define WSPR_ENC_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("encoder check failed");
`endif

// ===== hdl/wspr_enc_pkg.sv =====
// Types, constants and helper functions of the WSPR message symbol encoder.
// No dependencies; the front end, queue, back end and top use it by scoped names.
package wspr_enc_pkg;

	localparam int SYM_COUNT = 162;
	localparam logic [7:0] SYM_LAST = 8'd161;
	localparam logic [31:0] POLY_A = 32'hF2D05351;
	localparam logic [31:0] POLY_B = 32'hE4613C47;

	// Sync vector, symbol 0 is the leftmost bit.
	localparam logic [0:161] SYNC_VEC = {
		24'b110000001000111000100101,
		24'b111000000010010100000010,
		24'b110011010001101000011010,
		24'b101010010010110001101010,
		24'b001000001001001110110011,
		24'b010001110000010100110000,
		18'b000110101100011000};

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_CALL    = 2'd1,
		STAT_LOCATOR = 2'd2,
		STAT_POWER   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ERR,
		B_ENC,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		status_t status;
		logic [49:0] msg;
	} job_t;

	typedef logic [7:0] ilv_map_t [0:161];

	// Maps each coded bit to its slot in the interleaved frame.
	function automatic ilv_map_t build_ilv();
		ilv_map_t map;
		int i;
		int b;
		int p;
		logic [7:0] v;
		logic [7:0] j;
		map = '{default: '0};
		p = 0;
		for (i = 0; i < 256; i++) begin
			v = 8'(i);
			for (b = 0; b < 8; b++) begin
				j[b] = v[7 - b];
			end
			if (j < 8'(SYM_COUNT) && p < SYM_COUNT) begin
				map[p] = j;
				p++;
			end
		end
		return map;
	endfunction

	localparam ilv_map_t ILV_MAP = build_ilv();

	function automatic logic [5:0] char_code(input logic [7:0] c);
		logic [5:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = 6'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			r = 6'(c - 8'h41 + 8'd10);
		end else if (c == 8'h20) begin
			r = 6'd36;
		end else begin
			r = 6'd37;
		end
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

// ===== hdl/wspr_enc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wspr_enc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 162
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/wspr_enc_front.sv =====
// Front end: accepts a message, checks it and packs the 50 message bits.
// Depends on wspr_enc_pkg.
module wspr_enc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [47:0]         callsign_chars,
	input  logic [31:0]         locator_chars,
	input  logic [15:0]         power_chars,
	output logic                job_valid,
	input  logic                job_ready,
	output wspr_enc_pkg::job_t  job
);

	wspr_enc_pkg::front_state_t state_q, state_nx;
	wspr_enc_pkg::status_t status_q, status_in;

	logic [7:0] lb [4];
	logic [7:0] cb [6];
	logic [7:0] al [6];
	logic [7:0] p0, p1;
	logic [2:0] end_pos, dig_pos, pos;
	logic dig_found, seen_zero, loc_bad, pwr_bad, call_bad, accept;

	logic [5:0] code_q [6];
	logic [7:0] c0_q, c1_q, c2_q, c3_q;
	logic [6:0] pwr_q;
	logic [2:0] step_q;
	logic [27:0] n_q, n_nx;
	logic [21:0] t_q, m_q;

	assign accept = push && !full;

	always_comb begin
		loc_bad = 1'b0;
		for (int i = 0; i < 4; i++) begin
			lb[i] = locator_chars[31 - 8 * i -: 8];
			if (lb[i] == 8'd0) begin
				loc_bad = 1'b1;
			end
		end
		p0 = power_chars[15:8];
		p1 = power_chars[7:0];
		pwr_bad = !wspr_enc_pkg::is_digit(p0) || !wspr_enc_pkg::is_digit(p1);
		end_pos = 3'd6;
		dig_pos = 3'd0;
		dig_found = 1'b0;
		seen_zero = 1'b0;
		for (int i = 0; i < 6; i++) begin
			cb[i] = callsign_chars[47 - 8 * i -: 8];
			if (!seen_zero) begin
				if (cb[i] == 8'd0) begin
					seen_zero = 1'b1;
					end_pos = 3'(i);
				end else if (!dig_found && wspr_enc_pkg::is_digit(cb[i])) begin
					dig_found = 1'b1;
					dig_pos = 3'(i);
				end
			end
		end
		call_bad = !dig_found || dig_pos == 3'd0 || dig_pos > 3'd2;
		if (dig_pos == 3'd2) begin
			al[0] = cb[0];
			al[1] = cb[1];
			al[2] = cb[2];
		end else begin
			al[0] = 8'h20;
			al[1] = cb[0];
			al[2] = cb[1];
		end
		pos = 3'd0;
		for (int i = 3; i < 6; i++) begin
			pos = 3'(dig_pos + 3'(i - 2));
			al[i] = (pos < end_pos) ? cb[pos] : 8'h20;
		end
		if (loc_bad) begin
			status_in = wspr_enc_pkg::STAT_LOCATOR;
		end else if (pwr_bad) begin
			status_in = wspr_enc_pkg::STAT_POWER;
		end else if (call_bad) begin
			status_in = wspr_enc_pkg::STAT_CALL;
		end else begin
			status_in = wspr_enc_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wspr_enc_pkg::F_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			wspr_enc_pkg::F_IDLE: begin
				if (accept) begin
					state_nx = (status_in == wspr_enc_pkg::STAT_OK) ?
						wspr_enc_pkg::F_CALC : wspr_enc_pkg::F_PUSH;
				end
			end
			wspr_enc_pkg::F_CALC: begin
				if (step_q == 3'd5) begin
					state_nx = wspr_enc_pkg::F_PUSH;
				end
			end
			wspr_enc_pkg::F_PUSH: begin
				if (job_ready) begin
					state_nx = wspr_enc_pkg::F_IDLE;
				end
			end
			default: state_nx = wspr_enc_pkg::F_IDLE;
		endcase
	end

	// One multiply-add of the callsign code per step after step 0, which loads the first code.
	always_comb begin
		case (step_q)
			3'd0: n_nx = 28'(code_q[0]);
			3'd1: n_nx = 28'(n_q * 28'd36) + 28'(code_q[1]);
			3'd2: n_nx = 28'(n_q * 28'd10) + 28'(code_q[2]);
			default: n_nx = 28'(n_q * 28'd27) + 28'(code_q[step_q]) - 28'd10;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
		end else if (accept) begin
			step_q <= 3'd0;
		end else if (state_q == wspr_enc_pkg::F_CALC) begin
			step_q <= 3'(step_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_in;
			for (int i = 0; i < 6; i++) begin
				code_q[i] <= wspr_enc_pkg::char_code(al[i]);
			end
			c0_q <= 8'(8'(wspr_enc_pkg::char_code(lb[0])) - 8'd10);
			c1_q <= 8'(8'(wspr_enc_pkg::char_code(lb[1])) - 8'd10);
			c2_q <= 8'(lb[2] - 8'd48);
			c3_q <= 8'(lb[3] - 8'd48);
			pwr_q <= 7'(7'(p0[3:0]) * 7'd10 + 7'(p1[3:0]));
			n_q <= 28'd0;
			t_q <= 22'd0;
			m_q <= 22'd0;
		end else if (state_q == wspr_enc_pkg::F_CALC) begin
			n_q <= n_nx;
			if (step_q == 3'd0) begin
				t_q <= 22'd179 - 22'(22'(c0_q) * 22'd10) - 22'(c2_q);
			end
			if (step_q == 3'd1) begin
				m_q <= 22'({t_q * 22'd180 + 22'(22'(c1_q) * 22'd10) + 22'(c3_q), 7'd0})
					+ 22'(pwr_q) + 22'd64;
			end
		end
	end

	assign full = (state_q != wspr_enc_pkg::F_IDLE);
	assign job_valid = (state_q == wspr_enc_pkg::F_PUSH);
	assign job.status = status_q;
	assign job.msg = {n_q, m_q};

endmodule

// ===== hdl/wspr_enc_fifo.sv =====
// Two-entry queue that decouples the front end from the back end.
// Depends on wspr_enc_pkg.
module wspr_enc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wspr_enc_pkg::job_t in_job,
	output logic               out_valid,
	input  logic               out_ready,
	output wspr_enc_pkg::job_t out_job
);

	wspr_enc_pkg::job_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic wr_fire, rd_fire;

	assign in_ready = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign wr_fire = in_valid && in_ready;
	assign rd_fire = out_valid && out_ready;
	assign out_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_fire) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= 2'(count_q + 2'(wr_fire) - 2'(rd_fire));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			slot_q[wr_ptr_q] <= in_job;
		end
	end

endmodule

// ===== hdl/wspr_enc_back.sv =====
// Back end: convolutional coding into the interleave RAM, then symbol emission; a rejected job gives an error result.
// Depends on wspr_enc_pkg, wspr_enc_ram and the assertion header.
`include "wspr_message_symbol_encoder_assert.svh"
module wspr_enc_back #(
	parameter int SYMBOLS_PER_RESULT = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  wspr_enc_pkg::job_t job,
	output logic               empty,
	input  logic               pop,
	output logic [11:0]        symbol_group,
	output logic               last_group,
	output logic [1:0]         status
);

	wspr_enc_pkg::back_state_t state_q, state_nx;
	wspr_enc_pkg::status_t job_status_q, out_status_q;

	logic [49:0] msg_q;
	logic [31:0] reg_q, reg_shift;
	logic [7:0] p_q, rd_idx_q, idx_s1;
	logic dv_s1, coded_bit, rd_data, issue, stall, complete, out_free;
	logic [2:0] slot_q;
	logic [11:0] grp_q, grp_nx;
	logic [1:0] sym;
	logic out_valid_q, last_q;
	logic [11:0] out_grp_q;

	assign reg_shift = {reg_q[30:0], msg_q[49]};
	// Even coded bits shift in a message bit first, odd ones reuse the register.
	assign coded_bit = p_q[0] ? ^(reg_q & wspr_enc_pkg::POLY_B)
		: ^(reg_shift & wspr_enc_pkg::POLY_A);

	wspr_enc_ram #(.WIDTH(1), .DEPTH(wspr_enc_pkg::SYM_COUNT)) u_store (
		.clk     (clk),
		.wr_en   (state_q == wspr_enc_pkg::B_ENC),
		.wr_addr (wspr_enc_pkg::ILV_MAP[p_q]),
		.wr_data (coded_bit),
		.rd_en   (issue),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	assign out_free = !out_valid_q || pop;
	assign sym = {rd_data, wspr_enc_pkg::SYNC_VEC[idx_s1]};
	assign complete = (slot_q == 3'(SYMBOLS_PER_RESULT - 1)) || (idx_s1 == wspr_enc_pkg::SYM_LAST);
	// A finished group that cannot be transferred holds the read pipeline.
	assign stall = dv_s1 && complete && !out_free;
	assign issue = (state_q == wspr_enc_pkg::B_EMIT) && (rd_idx_q < 8'(wspr_enc_pkg::SYM_COUNT))
		&& !stall;

	always_comb begin
		grp_nx = grp_q;
		for (int s = 0; s < 6; s++) begin
			if (slot_q == 3'(s)) begin
				grp_nx[2 * s +: 2] = sym;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wspr_enc_pkg::B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		job_ready = 1'b0;
		unique case (state_q)
			wspr_enc_pkg::B_IDLE: begin
				if (job_valid) begin
					job_ready = 1'b1;
					state_nx = (job.status == wspr_enc_pkg::STAT_OK) ?
						wspr_enc_pkg::B_ENC : wspr_enc_pkg::B_ERR;
				end
			end
			wspr_enc_pkg::B_ERR: begin
				if (out_free) begin
					state_nx = wspr_enc_pkg::B_IDLE;
				end
			end
			wspr_enc_pkg::B_ENC: begin
				if (p_q == wspr_enc_pkg::SYM_LAST) begin
					state_nx = wspr_enc_pkg::B_EMIT;
				end
			end
			wspr_enc_pkg::B_EMIT: begin
				if (dv_s1 && !stall && idx_s1 == wspr_enc_pkg::SYM_LAST) begin
					state_nx = wspr_enc_pkg::B_IDLE;
				end
			end
			default: state_nx = wspr_enc_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= 8'd0;
			rd_idx_q <= 8'd0;
			dv_s1 <= 1'b0;
			slot_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			dv_s1 <= issue || stall;
			if (state_q == wspr_enc_pkg::B_IDLE) begin
				p_q <= 8'd0;
				rd_idx_q <= 8'd0;
				slot_q <= 3'd0;
			end
			if (state_q == wspr_enc_pkg::B_ENC) begin
				p_q <= 8'(p_q + 8'd1);
			end
			if (issue) begin
				rd_idx_q <= 8'(rd_idx_q + 8'd1);
			end
			if (dv_s1 && !stall) begin
				slot_q <= complete ? 3'd0 : 3'(slot_q + 3'd1);
			end
			if (state_q == wspr_enc_pkg::B_ERR && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dv_s1 && !stall && complete) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wspr_enc_pkg::B_IDLE) begin
			job_status_q <= job.status;
			msg_q <= job.msg;
			reg_q <= 32'd0;
			grp_q <= 12'd0;
		end
		if (state_q == wspr_enc_pkg::B_ENC && !p_q[0]) begin
			reg_q <= reg_shift;
			msg_q <= {msg_q[48:0], 1'b0};
		end
		if (issue) begin
			idx_s1 <= rd_idx_q;
		end
		if (dv_s1 && !stall) begin
			grp_q <= complete ? 12'd0 : grp_nx;
		end
		if (state_q == wspr_enc_pkg::B_ERR && out_free) begin
			out_grp_q <= 12'd0;
			last_q <= 1'b1;
			out_status_q <= job_status_q;
		end else if (dv_s1 && !stall && complete) begin
			out_grp_q <= grp_nx;
			last_q <= (idx_s1 == wspr_enc_pkg::SYM_LAST);
			out_status_q <= wspr_enc_pkg::STAT_OK;
		end
	end

	assign empty = !out_valid_q;
	assign symbol_group = out_grp_q;
	assign last_group = last_q;
	assign status = out_status_q;

	`WSPR_ENC_CHECK(a_err_result_shape, out_valid_q && out_status_q != wspr_enc_pkg::STAT_OK,
		out_grp_q == 12'd0 && last_q)
	`WSPR_ENC_CHECK(a_enc_index_range, state_q == wspr_enc_pkg::B_ENC,
		p_q < 8'(wspr_enc_pkg::SYM_COUNT))
	`WSPR_ENC_CHECK(a_read_index_range, state_q == wspr_enc_pkg::B_EMIT,
		rd_idx_q <= 8'(wspr_enc_pkg::SYM_COUNT))
	`WSPR_ENC_CHECK_NEXT(a_stall_keeps_symbol, stall, dv_s1 && $stable(idx_s1))

endmodule

// ===== hdl/wspr_message_symbol_encoder.sv =====
// An accepted message passes the front end's calculation steps and the two-entry queue to the
// back end, which codes the frame (one coded bit per cycle into the interleave RAM) and then
// emits it; it codes the whole frame before it emits any of it and takes no new message until
// its last group is formed. A rejected message skips the coding and gives its status alone.
// Reset (arst_n, asynchronous) clears all control state; the interleave RAM is not cleared.
module wspr_message_symbol_encoder #(
	parameter int SYMBOLS_PER_RESULT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [47:0] callsign_chars,
	input  logic [31:0] locator_chars,
	input  logic [15:0] power_chars,
	output logic        empty,
	input  logic        pop,
	output logic [11:0] symbol_group,
	output logic        last_group,
	output logic [1:0]  status
);

	wspr_enc_pkg::job_t front_job, back_job;
	logic front_valid, front_ready, back_valid, back_ready;

	wspr_enc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.callsign_chars (callsign_chars),
		.locator_chars  (locator_chars),
		.power_chars    (power_chars),
		.job_valid      (front_valid),
		.job_ready      (front_ready),
		.job            (front_job)
	);

	wspr_enc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_job    (front_job),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_job   (back_job)
	);

	wspr_enc_back #(.SYMBOLS_PER_RESULT(SYMBOLS_PER_RESULT)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (back_valid),
		.job_ready    (back_ready),
		.job          (back_job),
		.empty        (empty),
		.pop          (pop),
		.symbol_group (symbol_group),
		.last_group   (last_group),
		.status       (status)
	);

endmodule
